>>> src/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types, constants and ring helpers for the deque with value search.
// ----------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_FIND       = 3'd5
  } dqs_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } dqs_status_e;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } dqs_state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic scan_start;
    logic scan_step;
    logic scan_end;
  } dqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_req;
    logic match;
    logic last;
  } dqs_stat_t;

  // ring slot that lies off positions after head, off <= DEPTH
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] r;
    if (head == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = head - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/dqs_ram.sv
// ----------------------------------------------------------------------------
// dqs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/dqs_ctrl.sv
// ----------------------------------------------------------------------------
// dqs_ctrl
// Controller: input and output handshakes and the find scan sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_ctrl
  import dqs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  input  wire dqs_stat_t stat_i,
  output      dqs_cmd_t  cmd_o
);

  dqs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        accept     = in_valid_i && !in_stall_o;
        if (accept) begin
          if (stat_i.scan_req) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.match || stat_i.last) begin
          cmd_o.scan_end = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign load = cmd_o.exec || cmd_o.scan_end;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/dqs_dp.sv
// ----------------------------------------------------------------------------
// dqs_dp
// Datapath: ring pointers, entry store, find compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqs_dp
  import dqs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  input  wire dqs_cmd_t                  cmd_i,
  output      dqs_stat_t                 stat_o,
  output      logic [STAT_W-1:0]         status_o,
  output      logic                      found_o,
  output      logic [POS_W-1:0]          position_o,
  output      logic [COUNT_W-1:0]        count_o
);

  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [DATA_W-1:0]  key_q;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [STAT_W-1:0]  res_status_q, res_status_d;
  logic               res_found_q, res_found_d;
  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  logic               full, empty;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;
  dqs_status_e        ex_status;
  dqs_op_e            op;

  assign op    = dqs_op_e'(operation_i);
  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  dqs_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr = cmd_i.scan_start ? head_q
                                  : ring_slot(head_q, CNT_W'(cmp_idx_q) + CNT_W'(1));

  assign stat_o.scan_req = (op == OP_FIND) && !empty;
  assign stat_o.match    = (rdata == key_q);
  assign stat_o.last     = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q);

  // operation decode for clear, push, pop and find on an empty deque
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ex_status = ST_OK;
    we        = 1'b0;
    waddr     = ring_slot(head_q, count_q);
    unique case (op)
      OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      OP_PUSH_BACK: begin
        if (full) begin
          ex_status = ST_FULL;
        end else begin
          we      = cmd_i.exec;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        waddr = ring_dec(head_q);
        if (full) begin
          ex_status = ST_FULL;
        end else begin
          we      = cmd_i.exec;
          head_d  = ring_dec(head_q);
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          ex_status = ST_EMPTY;
        end else begin
          head_d  = ring_slot(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          ex_status = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmp_idx_d    = cmp_idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    res_count_d  = res_count_q;
    if (cmd_i.exec) begin
      res_status_d = ex_status;
      res_found_d  = 1'b0;
      res_pos_d    = '0;
      res_count_d  = COUNT_W'(count_d);
    end else if (cmd_i.scan_end) begin
      res_status_d = ST_OK;
      res_found_d  = stat_o.match;
      res_pos_d    = stat_o.match ? POS_W'(cmp_idx_q) : '0;
      res_count_d  = COUNT_W'(count_q);
    end
    if (cmd_i.scan_start) begin
      cmp_idx_d = '0;
    end else if (cmd_i.scan_step) begin
      cmp_idx_d = cmp_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      cmp_idx_q    <= '0;
      res_status_q <= ST_OK;
      res_found_q  <= 1'b0;
      res_pos_q    <= '0;
      res_count_q  <= '0;
    end else begin
      if (cmd_i.exec) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      cmp_idx_q    <= cmp_idx_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_pos_q    <= res_pos_d;
      res_count_q  <= res_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      key_q <= value_i;
    end
  end

  assign status_o   = res_status_q;
  assign found_o    = res_found_q;
  assign position_o = res_pos_q;
  assign count_o    = res_count_q;

endmodule

`default_nettype wire

>>> src/deque_with_value_search.sv
// ----------------------------------------------------------------------------
// deque_with_value_search
// Bounded double-ended queue of 32-bit values with a find-by-value scan.
// ----------------------------------------------------------------------------
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   operation_i, value_i
//   out      output     out_valid_o / out_stall_i status_o, found_o,
//                                                 position_o, count_o
//
// clear, push and pop register their result at the transfer edge.
// find walks the ring one entry per cycle through the registered ram read
// port and registers its result at the first match or at the last entry.
// one item at a time; a new transfer is taken while the result register
// drains. reset clears pointers and count; the entry ram is not cleared.
// a stalled result holds and blocks new transfers until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_value_search
  import dqs_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [OP_W-1:0]           operation_i,
  input  wire logic signed [DATA_W-1:0]  value_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic [STAT_W-1:0]         status_o,
  output      logic                      found_o,
  output      logic [POS_W-1:0]          position_o,
  output      logic [COUNT_W-1:0]        count_o
);

  dqs_cmd_t  cmd;
  dqs_stat_t stat;

  dqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dqs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operation_i (operation_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .found_o     (found_o),
    .position_o  (position_o),
    .count_o     (count_o)
  );

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> count_o == COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> count_o == '0)
    else $error("empty status with nonzero count");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("found result with error status");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_start |=> in_stall_o)
    else $error("input taken during find scan");

endmodule

`default_nettype wire
